// ===== sv/sha1sh_pkg.sv =====
// Shared types, constants and round functions of the SHA-1 stream hasher.
// Depends on nothing; every other file of the block imports it.
package sha1sh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumH    = 5;
  localparam int unsigned NumW    = 16;
  localparam int unsigned NumRnd  = 80;
  localparam int unsigned RndW    = 7;
  localparam int unsigned FillW   = 6;
  localparam int unsigned TotalW  = 61;

  localparam logic [WordW-1:0] K0 = 32'h5A82_7999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9_EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1B_BCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62_C1D6;

  localparam logic [NumH-1:0][WordW-1:0] HInit = {
    32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
  };

  localparam logic [7:0]       PadByte    = 8'h80;
  localparam logic [FillW-1:0] LenPos     = 6'd56;
  localparam logic [FillW-1:0] LastPos    = 6'd63;
  localparam logic [RndW-1:0]  LastRound  = 7'd79;
  localparam logic [2:0]       LastWordIx = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_e;

  // Control of the block buffer and message schedule.
  typedef struct packed {
    logic             wr_byte;
    logic [FillW-1:0] byte_idx;
    logic [7:0]       byte_val;
    logic             wr_len;
    logic             shift;
  } buf_ctrl_t;

  // Control of the round unit.
  typedef struct packed {
    logic init;   // chaining value back to the initial constants
    logic start;  // working variables from the chaining value
    logic step;   // one compression round
    logic fold;   // chaining value plus working variables
  } rnd_ctrl_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] x);
    rotl1 = {x[WordW-2:0], x[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] rotl5(input logic [WordW-1:0] x);
    rotl5 = {x[WordW-6:0], x[WordW-1:WordW-5]};
  endfunction

  function automatic logic [WordW-1:0] rotl30(input logic [WordW-1:0] x);
    rotl30 = {x[1:0], x[WordW-1:2]};
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RndW-1:0] r,
                                                 input logic [WordW-1:0] b,
                                                 input logic [WordW-1:0] c,
                                                 input logic [WordW-1:0] d);
    if (r < 7'd20) begin
      round_f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      round_f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] r);
    if (r < 7'd20) begin
      round_k = K0;
    end else if (r < 7'd40) begin
      round_k = K1;
    end else if (r < 7'd60) begin
      round_k = K2;
    end else begin
      round_k = K3;
    end
  endfunction

endpackage

// ===== sv/sha1sh_msg_buf.sv =====
// Block buffer of sixteen big-endian words that doubles as the rolling
// message schedule during compression. Depends on sha1sh_pkg.
module sha1sh_msg_buf (
  input  logic                         clk_i,
  input  sha1sh_pkg::buf_ctrl_t        ctrl_i,
  input  logic [63:0]                  len_bits_i,
  output logic [sha1sh_pkg::WordW-1:0] w_o
);
  import sha1sh_pkg::*;

  logic [WordW-1:0] words_q [NumW];
  logic [WordW-1:0] w_next;

  // Next schedule word from the window, oldest word at position zero.
  assign w_next = rotl1(words_q[13] ^ words_q[8] ^ words_q[2] ^ words_q[0]);
  assign w_o    = words_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < NumW - 1; i++) begin
        words_q[i] <= words_q[i+1];
      end
      words_q[NumW-1] <= w_next;
    end else begin
      if (ctrl_i.wr_byte) begin
        for (int i = 0; i < NumW; i++) begin
          if (ctrl_i.byte_idx[FillW-1:2] == 4'(i)) begin
            case (ctrl_i.byte_idx[1:0])
              2'd0:    words_q[i][31:24] <= ctrl_i.byte_val;
              2'd1:    words_q[i][23:16] <= ctrl_i.byte_val;
              2'd2:    words_q[i][15:8]  <= ctrl_i.byte_val;
              default: words_q[i][7:0]   <= ctrl_i.byte_val;
            endcase
          end
        end
      end
      if (ctrl_i.wr_len) begin
        words_q[NumW-2] <= len_bits_i[63:32];
        words_q[NumW-1] <= len_bits_i[31:0];
      end
    end
  end

endmodule

// ===== sv/sha1sh_round.sv =====
// Shared SHA-1 round unit: chaining value, working variables and round
// counter, one round per cycle. Depends on sha1sh_pkg.
module sha1sh_round (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  sha1sh_pkg::rnd_ctrl_t                       ctrl_i,
  input  logic [sha1sh_pkg::WordW-1:0]                w_i,
  output logic                                        last_round_o,
  output logic [sha1sh_pkg::NumH-1:0][sha1sh_pkg::WordW-1:0] chain_o
);
  import sha1sh_pkg::*;

  logic [NumH-1:0][WordW-1:0] chain_q, chain_d;
  logic [NumH-1:0][WordW-1:0] wv_q, wv_d;
  logic [RndW-1:0]            rnd_q, rnd_d;
  logic [WordW-1:0]           t_sum;

  assign t_sum = rotl5(wv_q[0]) + round_f(rnd_q, wv_q[1], wv_q[2], wv_q[3])
               + wv_q[4] + round_k(rnd_q) + w_i;

  always_comb begin
    chain_d = chain_q;
    wv_d    = wv_q;
    rnd_d   = rnd_q;
    if (ctrl_i.init) begin
      chain_d = HInit;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < NumH; i++) begin
        chain_d[i] = chain_q[i] + wv_q[i];
      end
    end
    if (ctrl_i.start) begin
      wv_d  = chain_q;
      rnd_d = '0;
    end else if (ctrl_i.step) begin
      wv_d[4] = wv_q[3];
      wv_d[3] = wv_q[2];
      wv_d[2] = rotl30(wv_q[1]);
      wv_d[1] = wv_q[0];
      wv_d[0] = t_sum;
      rnd_d   = (rnd_q == LastRound) ? '0 : rnd_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= HInit;
      rnd_q   <= '0;
    end else begin
      chain_q <= chain_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
  end

  assign last_round_o = (rnd_q == LastRound);
  assign chain_o      = chain_q;

endmodule

// ===== sv/sha1_stream_hasher_unit.sv =====
// Top level of the SHA-1 stream hasher: sequencer, byte counters and digest
// output register. Depends on sha1sh_pkg, sha1sh_msg_buf and sha1sh_round.
//
// Usage: the input channel carries one beat per message byte (mode_i low,
// byte on data_byte_i) or a finish beat (mode_i high) that closes the
// message. A beat is taken when in_valid_i is high and in_stall_o is low.
// Each finish beat yields five output beats on the digest channel, H0 first,
// word_index_o counting 0 to 4 and last_word_o high on the fifth.
// Flow: the byte that fills a 64-byte block sets off the rounds through
// the single shared round adder and then a fold of the result into the
// chaining value; other data bytes only go into the buffer. A finish beat
// writes padding one byte per cycle (up to 63 zero bytes) until the
// length slot is reached, then the length, compresses each final block
// (one or two blocks) and then hands out the five digest words, waiting
// while the receiver stalls.
// The input is stalled throughout all of that; it opens again in the cycle
// after the fifth word is loaded into the output register, so the next
// message may start while that word still waits to be taken.
// Reset loads the initial chaining value and clears the byte counters and
// the output valid; the block buffer itself is not cleared, since every
// byte of it is written before it is used. While out_stall_i is high the
// held digest word stays unchanged and a sequencer with words to send waits.
module sha1_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1sh_pkg::*;

  state_e                     state_q, state_d;
  logic [FillW-1:0]           fill_q, fill_d;
  logic [TotalW-1:0]          total_q, total_d;
  logic                       fin_q, fin_d;        // finishing a message
  logic                       pad_full_q, pad_full_d; // pad to block end first
  logic                       last_blk_q, last_blk_d; // block holds the length
  logic [2:0]                 idx_q, idx_d;
  logic                       ov_q, ov_d;
  logic [WordW-1:0]           word_q, word_d;
  logic [2:0]                 wix_q, wix_d;
  logic                       lw_q, lw_d;

  buf_ctrl_t                  buf_ctrl;
  rnd_ctrl_t                  rnd_ctrl;
  logic [WordW-1:0]           w_cur;
  logic                       last_round;
  logic [NumH-1:0][WordW-1:0] chain;
  logic [WordW-1:0]           chain_sel;
  logic                       in_acc;
  logic                       out_free;
  logic [FillW-1:0]           fill_inc;

  sha1sh_msg_buf u_buf (
    .clk_i      (clk_i),
    .ctrl_i     (buf_ctrl),
    .len_bits_i ({total_q, 3'b000}),
    .w_o        (w_cur)
  );

  sha1sh_round u_round (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (rnd_ctrl),
    .w_i          (w_cur),
    .last_round_o (last_round),
    .chain_o      (chain)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  assign fill_inc   = fill_q + 6'd1;

  always_comb begin
    case (idx_q)
      3'd0:    chain_sel = chain[0];
      3'd1:    chain_sel = chain[1];
      3'd2:    chain_sel = chain[2];
      3'd3:    chain_sel = chain[3];
      default: chain_sel = chain[4];
    endcase
  end

  // Sequencer: next state, counters and datapath controls.
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    total_d    = total_q;
    fin_d      = fin_q;
    pad_full_d = pad_full_q;
    last_blk_d = last_blk_q;
    idx_d      = idx_q;
    ov_d       = ov_q && out_stall_i;
    word_d     = word_q;
    wix_d      = wix_q;
    lw_d       = lw_q;
    buf_ctrl   = '0;
    rnd_ctrl   = '0;
    buf_ctrl.byte_idx = fill_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          buf_ctrl.wr_byte = 1'b1;
          fill_d           = fill_inc;
          if (!mode_i) begin
            buf_ctrl.byte_val = data_byte_i;
            total_d           = total_q + 61'd1;
            if (fill_q == LastPos) begin
              rnd_ctrl.start = 1'b1;
              state_d        = ST_COMP;
            end
          end else begin
            buf_ctrl.byte_val = PadByte;
            fin_d             = 1'b1;
            last_blk_d        = 1'b0;
            if (fill_q == LastPos) begin
              // The marker byte closes a block: compress it, then pad afresh.
              pad_full_d     = 1'b0;
              rnd_ctrl.start = 1'b1;
              state_d        = ST_COMP;
            end else begin
              pad_full_d = (fill_inc > LenPos);
              state_d    = ST_PAD;
            end
          end
        end
      end

      ST_PAD: begin
        if (!pad_full_q && fill_q == LenPos) begin
          state_d = ST_LEN;
        end else begin
          buf_ctrl.wr_byte  = 1'b1;
          buf_ctrl.byte_val = 8'h00;
          fill_d            = fill_inc;
          if (pad_full_q && fill_q == LastPos) begin
            pad_full_d     = 1'b0;
            rnd_ctrl.start = 1'b1;
            state_d        = ST_COMP;
          end
        end
      end

      ST_LEN: begin
        buf_ctrl.wr_len = 1'b1;
        last_blk_d      = 1'b1;
        rnd_ctrl.start  = 1'b1;
        state_d         = ST_COMP;
      end

      ST_COMP: begin
        rnd_ctrl.step  = 1'b1;
        buf_ctrl.shift = 1'b1;
        if (last_round) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        rnd_ctrl.fold = 1'b1;
        if (last_blk_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          word_d = chain_sel;
          wix_d  = idx_q;
          lw_d   = (idx_q == LastWordIx);
          idx_d  = idx_q + 3'd1;
          if (idx_q == LastWordIx) begin
            // Digest handed over: start the next message.
            rnd_ctrl.init = 1'b1;
            fill_d        = '0;
            total_d       = '0;
            fin_d         = 1'b0;
            last_blk_d    = 1'b0;
            state_d       = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      total_q    <= '0;
      fin_q      <= 1'b0;
      pad_full_q <= 1'b0;
      last_blk_q <= 1'b0;
      idx_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      total_q    <= total_d;
      fin_q      <= fin_d;
      pad_full_q <= pad_full_d;
      last_blk_q <= last_blk_d;
      idx_q      <= idx_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    wix_q  <= wix_d;
    lw_q   <= lw_d;
  end

  assign out_valid_o   = ov_q;
  assign digest_word_o = word_q;
  assign word_index_o  = wix_q;
  assign last_word_o   = lw_q;

  // The length words only ever go in once the buffer is padded to them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LEN |-> fill_q == LenPos)
    else $error("length written at wrong fill position");

  // A finish beat always leads the sequencer away from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_i |=> state_q == ST_PAD || state_q == ST_COMP)
    else $error("finish beat not followed by padding or compression");

  // Words leave in order, the flagged one being the fifth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && lw_q |-> wix_q == LastWordIx)
    else $error("last digest word flagged at wrong index");

  // Compression only runs with the buffer shifting in step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_ctrl.step |-> buf_ctrl.shift && !buf_ctrl.wr_byte && !buf_ctrl.wr_len)
    else $error("buffer written during compression");

endmodule

// ===== test/tb_sha1_stream_hasher_unit.sv =====
// Self-checking testbench for the SHA-1 stream hasher: streams message bytes and finish
// beats into the block and compares every digest word with a behavioural SHA-1 model.
// Depends on sha1sh_pkg and on the RTL of sha1_stream_hasher_unit.
module tb_sha1_stream_hasher_unit;
  import sha1sh_pkg::*;

  // Codes carried on mode_i.
  localparam logic ModeData   = 1'b0;
  localparam logic ModeFinish = 1'b1;

  // The run is abandoned if it goes on for longer than this many cycles.
  localparam int unsigned CycleLimit = 400000;
  // Cycles allowed after the last digest word for the block to settle.
  localparam int unsigned SettleCycles = 300;
  // Length of the one long hold-off on the digest channel.
  localparam int unsigned LongHold = 800;

  // One beat of the input channel. The drain flag is testbench-only: the sender does not
  // offer this beat until every digest word already owed has been taken.
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       drain;
  } msg_beat_t;

  // One beat of the digest channel.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        mode_i      = ModeData;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha1_stream_hasher_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Beats still to be offered, and digest words predicted but not yet seen.
  msg_beat_t    pending_q[$];
  digest_beat_t digest_q[$];

  // Behavioural hash state: chaining value, the partly filled block and the byte count.
  logic [31:0] chain_h [NumH];
  logic [7:0]  blk [64];
  logic [5:0]  blk_fill;
  logic [60:0] msg_bytes;

  // Bookkeeping. words_owed is advanced by the sender as finish beats go in, words_seen
  // by the monitor as digest words come out; the sender compares the two to drain.
  int unsigned words_owed    = 0;
  int unsigned words_seen    = 0;
  int unsigned errors        = 0;
  int unsigned cycles        = 0;
  int unsigned beats_sent    = 0;
  int unsigned msgs_queued   = 0;
  int unsigned bytes_queued  = 0;
  int unsigned longest_msg   = 0;
  int unsigned items_queued  = 0;
  int unsigned gap_left      = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < NumH; i++) chain_h[i] = HInit[i];
    blk_fill  = '0;
    msg_bytes = '0;
  endtask

  // One SHA-1 compression of the 64-byte block into the chaining value. The message
  // schedule is kept as a rolling window of sixteen words.
  task automatic sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int j = 0; j < 16; j++) begin
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r%16] = rol32(w[(r-3)%16] ^ w[(r-8)%16] ^ w[(r-14)%16] ^ w[r%16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol32(a, 5) + f + e + k + w[r%16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  // Applies one accepted input beat to the hash state. A data beat only fills the block
  // (compressing it when full); a finish beat pads, appends the bit length, compresses
  // the last one or two blocks and queues the five digest words.
  task automatic absorb_beat(input msg_beat_t bt);
    logic [63:0]  bit_len;
    digest_beat_t dw;
    if (bt.mode == ModeData) begin
      blk[blk_fill] = bt.data;
      blk_fill      = blk_fill + 1'b1;
      msg_bytes     = msg_bytes + 1'b1;
      if (blk_fill == 0) sha1_compress();
    end else begin
      bit_len       = {msg_bytes, 3'b000};
      blk[blk_fill] = PadByte;
      blk_fill      = blk_fill + 1'b1;
      if (blk_fill == 0) begin
        sha1_compress();
      end else if (blk_fill > LenPos) begin
        // No room left for the length: pad this block out and start another.
        for (int i = blk_fill; i < 64; i++) blk[i] = 8'h00;
        sha1_compress();
        blk_fill = '0;
      end
      for (int i = blk_fill; i < LenPos; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[LenPos + i] = bit_len[63 - 8*i -: 8];
      sha1_compress();
      for (int i = 0; i < NumH; i++) begin
        dw.word = chain_h[i];
        dw.idx  = 3'(i);
        dw.last = (i == NumH - 1);
        digest_q.push_back(dw);
      end
      words_owed += NumH;
      restart_hash();
    end
  endtask

  task automatic push_beat(input logic mode, input logic [7:0] data, input logic drain);
    msg_beat_t bt;
    bt.mode  = mode;
    bt.data  = data;
    bt.drain = drain;
    pending_q.push_back(bt);
    items_queued++;
    if (mode == ModeData) begin
      bytes_queued++;
    end else begin
      msgs_queued++;
    end
  endtask

  // Queues a whole message of random bytes and its finish beat, which carries a random
  // (and meaningless) data byte. The drain flag, if set, sits on the first beat.
  task automatic queue_message(input int unsigned len, input logic drain);
    for (int i = 0; i < len; i++) begin
      push_beat(ModeData, 8'($urandom_range(0, 255)), drain && (i == 0));
    end
    push_beat(ModeFinish, 8'($urandom_range(0, 255)), drain && (len == 0));
    if (len > longest_msg) longest_msg = len;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at cycle %0d: %s: got %h, expected %h", cycles, what, got, want);
    errors++;
  endtask

  // Sender. Beats go out in bursts of random length with random gaps between them. A
  // beat stays on the wires, unchanged, until the block takes it. The next valid level
  // is worked out in a variable first so that in_valid_i gets one assignment per edge.
  always @(posedge clk_i) begin
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        absorb_beat(pending_q.pop_front());
        beats_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0 &&
                     (!pending_q[0].drain || words_owed == words_seen)) begin
          nxt_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // Mostly short bursts, now and then a long one with no idling at all.
            gap_left   = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
          end
        end
      end
      in_valid_i <= nxt_valid;
      if (nxt_valid) begin
        mode_i      <= pending_q[0].mode;
        data_byte_i <= pending_q[0].data;
      end
    end
  end

  // Receiver. The stall pattern changes with every digest taken: none, even odds,
  // mostly stalled and strictly alternating. Once, after three digests, when the held
  // back message is let go, it holds off for a long stretch while the sender keeps
  // offering beats, so that the block backs up and stalls its input.
  always @(posedge clk_i) begin
    logic stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!hold_done && words_seen >= 3 * NumH) begin
        hold_done = 1'b1;
        hold_left = LongHold;
        stall     = 1'b1;
      end else begin
        case ((words_seen / NumH) % 4)
          0: stall = 1'b0;
          1: stall = ($urandom_range(0, 1) == 0);
          2: stall = ($urandom_range(0, 4) != 0);
          default: stall = ~out_stall_i;
        endcase
      end
      out_stall_i <= stall;
    end
  end

  // Monitor. Every digest beat taken is checked field by field against the oldest
  // prediction.
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest word with nothing expected", digest_word_o, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) begin
          report_mismatch("digest_word", digest_word_o, want.word);
        end
        if (word_index_o !== want.idx) begin
          report_mismatch("word_index", 32'(word_index_o), 32'(want.idx));
        end
        if (last_word_o !== want.last) begin
          report_mismatch("last_word", 32'(last_word_o), 32'(want.last));
        end
      end
      words_seen <= words_seen + 1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("sha1_stream_hasher_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned len;
    int unsigned rand_items;
    int unsigned rand_msgs;
    restart_hash();
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;

    // Directed part. Two empty messages back to back, the first finish carrying a stray
    // all-ones byte that must be ignored; the classic three-byte "abc"; then short
    // messages of all-zero, all-ones and mixed bytes, one of them held back until the
    // earlier digests have drained.
    push_beat(ModeFinish, 8'hFF, 1'b0);
    push_beat(ModeFinish, 8'h00, 1'b0);
    push_beat(ModeData, 8'h61, 1'b0);
    push_beat(ModeData, 8'h62, 1'b0);
    push_beat(ModeData, 8'h63, 1'b0);
    push_beat(ModeFinish, 8'h5A, 1'b0);
    push_beat(ModeData, 8'h00, 1'b1);
    push_beat(ModeFinish, 8'hAA, 1'b0);
    push_beat(ModeData, 8'hFF, 1'b0);
    push_beat(ModeFinish, 8'h00, 1'b0);
    push_beat(ModeData, 8'h80, 1'b0);
    push_beat(ModeData, 8'h7F, 1'b0);
    push_beat(ModeData, 8'h01, 1'b0);
    push_beat(ModeData, 8'hFE, 1'b0);
    push_beat(ModeFinish, 8'hFF, 1'b0);
    longest_msg = 4;

    // Random part. Mostly short messages, a good share with lengths at the padding
    // boundaries (just below, at and just above the length slot, one block less one,
    // one block, one block plus one) and some longer ones of up to three blocks.
    rand_items = 0;
    rand_msgs  = 0;
    while (rand_items < 190 || rand_msgs < 8) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        len = $urandom_range(0, 12);
      end else if (sel < 9) begin
        case ($urandom_range(0, 5))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          default: len = 65;
        endcase
      end else begin
        len = $urandom_range(13, 130);
      end
      queue_message(len, $urandom_range(0, 3) == 0);
      rand_items += len + 1;
      rand_msgs++;
    end

    // Reset is held low, then released on a clock edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (words_seen != words_owed) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (digest_q.size() != 0) begin
      report_mismatch("digest words never delivered", digest_q.size(), 32'h0);
    end
    $display("Hashed %0d messages (%0d bytes, longest %0d) in %0d beats over %0d cycles.",
             msgs_queued, bytes_queued, longest_msg, beats_sent, cycles);
    $display("Checked %0d digest words, including one long hold-off on the output.",
             words_seen);
    if (errors == 0) begin
      $display("sha1_stream_hasher_unit: match");
    end else begin
      $display("sha1_stream_hasher_unit: mismatch");
    end
    $finish;
  end

endmodule
